### hdl/bsmirq_pkg.sv
// Shared types, codes and constants for the bank switch mapper with scanline interrupt.
package bsmirq_pkg;

	localparam int PRG_CNT_W = 9;
	localparam int CHR_CNT_W = 11;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 11;
	localparam int Q_DEPTH = 2;
	localparam int Q_AW = 1;
	localparam int Q_CW = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_PRG_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CHR_COUNT = 1'd1;

	localparam logic [PRG_CNT_W-1:0] PRG_COUNT_RST = 9'd2;
	localparam logic [CHR_CNT_W-1:0] CHR_COUNT_RST = 11'd8;

	// address high nibble decode
	localparam logic [3:0] NIB_PRG_A = 4'h8;
	localparam logic [3:0] NIB_MIRROR = 4'h9;
	localparam logic [3:0] NIB_PRG_B = 4'hA;
	localparam logic [3:0] NIB_CHR_FIRST = 4'hB;
	localparam logic [3:0] NIB_CHR_LAST = 4'hE;
	localparam logic [3:0] NIB_IRQ = 4'hF;

	// folded sub-address codes in the interrupt group
	localparam logic [1:0] IRQ_LATCH_LO = 2'd0;
	localparam logic [1:0] IRQ_LATCH_HI = 2'd1;
	localparam logic [1:0] IRQ_CONTROL = 2'd2;
	localparam logic [1:0] IRQ_ACK = 2'd3;

	localparam logic [7:0] CNT_TOP = 8'hFF;

	typedef enum logic [2:0] {
		EFF_NONE = 3'd0,
		EFF_PRG = 3'd1,
		EFF_CHR = 3'd2,
		EFF_MIRROR = 3'd3,
		EFF_IRQ = 3'd4
	} effect_t;

	// request passed from front to back
	typedef struct packed {
		effect_t effect;
		logic [2:0] slot;
		logic [7:0] value;
		logic [1:0] mirror;
	} req_t;

	// result item, effect in the lowest bits
	typedef struct packed {
		logic irq_request;
		logic [1:0] mirror_mode;
		logic [7:0] bank;
		logic [2:0] slot;
		effect_t effect;
	} res_t;

	localparam int RES_W = $bits(res_t);

endpackage

### hdl/bsmirq_front.sv
// Front end: accepts writes and ticks, updates mapper state, queues a classified request.
module bsmirq_front (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic kind,
	input  logic [15:0] addr,
	input  logic [7:0] data,
	input  logic q_full,
	output logic in_ready,
	output logic push,
	output bsmirq_pkg::req_t push_req
);
	import bsmirq_pkg::*;

	logic [7:0] chr_q [8];
	logic swap_q;
	logic [1:0] en_q;
	logic [7:0] cnt_q;
	logic [7:0] reload_q;

	logic [3:0] nib;
	logic [1:0] sub;
	logic [3:0] chr_off;
	logic [2:0] idx;
	logic [7:0] chr_new;
	logic acc;

	assign in_ready = !q_full;
	assign acc = in_valid && in_ready;
	assign push = acc;

	assign nib = addr[15:12];
	assign sub = addr[3:2] | addr[1:0];
	assign chr_off = nib - NIB_CHR_FIRST;
	assign idx = {chr_off[1:0], sub[1]};
	assign chr_new = sub[0] ? {data[3:0], chr_q[idx][3:0]} : {chr_q[idx][7:4], data[3:0]};

	always_comb begin
		push_req = '0;
		push_req.effect = EFF_NONE;
		if (kind) begin
			if (en_q[1] && cnt_q == CNT_TOP)
				push_req.effect = EFF_IRQ;
		end else if (nib == NIB_PRG_A || nib == NIB_PRG_B) begin
			push_req.effect = EFF_PRG;
			push_req.value = data;
			if (nib == NIB_PRG_B)
				push_req.slot = 3'd1;
			else
				push_req.slot = swap_q ? 3'd2 : 3'd0;
		end else if (nib == NIB_MIRROR) begin
			if (!sub[1]) begin
				push_req.effect = EFF_MIRROR;
				push_req.mirror = data[1:0] ^ 2'b01;
			end
		end else if (nib >= NIB_CHR_FIRST && nib <= NIB_CHR_LAST) begin
			push_req.effect = EFF_CHR;
			push_req.slot = idx;
			push_req.value = chr_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++)
				chr_q[i] <= 8'(i);
			swap_q <= 1'b0;
			en_q <= 2'b00;
			cnt_q <= 8'd0;
			reload_q <= 8'd0;
		end else if (acc) begin
			if (kind) begin
				if (en_q[1]) begin
					if (cnt_q == CNT_TOP) begin
						cnt_q <= reload_q;
						en_q <= {en_q[0], en_q[0]};
					end else begin
						cnt_q <= cnt_q + 8'd1;
					end
				end
			end else if (nib == NIB_MIRROR) begin
				if (sub[1])
					swap_q <= data[1];
			end else if (nib >= NIB_CHR_FIRST && nib <= NIB_CHR_LAST) begin
				chr_q[idx] <= chr_new;
			end else if (nib == NIB_IRQ) begin
				case (sub)
					IRQ_LATCH_LO: reload_q[3:0] <= data[3:0];
					IRQ_LATCH_HI: reload_q[7:4] <= data[3:0];
					IRQ_CONTROL: begin
						en_q <= data[1:0];
						if (data[1])
							cnt_q <= reload_q;
					end
					IRQ_ACK: en_q <= {en_q[0], en_q[0]};
					default: en_q <= en_q;
				endcase
			end
		end
	end

endmodule

### hdl/bsmirq_fifo.sv
// Two-entry request queue between front and back.
module bsmirq_fifo (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  bsmirq_pkg::req_t push_req,
	input  logic pop,
	output logic full,
	output logic empty,
	output bsmirq_pkg::req_t pop_req
);
	import bsmirq_pkg::*;

	req_t mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_q;
	logic [Q_AW-1:0] rd_q;
	logic [Q_CW-1:0] count_q;

	assign full = count_q == Q_CW'(Q_DEPTH);
	assign empty = count_q == '0;
	assign pop_req = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			case ({push, pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### hdl/bsmirq_back.sv
// Back end: reduces bank numbers by the page count two bits a cycle and holds the result.
module bsmirq_back (
	input  logic clk,
	input  logic arst_n,
	input  logic [bsmirq_pkg::PRG_CNT_W-1:0] prg_count,
	input  logic [bsmirq_pkg::CHR_CNT_W-1:0] chr_count,
	input  logic q_empty,
	input  bsmirq_pkg::req_t q_req,
	output logic pop,
	output logic out_valid,
	input  logic out_ready,
	output bsmirq_pkg::res_t out_res
);
	import bsmirq_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_DIV = 3'b010,
		S_DONE = 3'b100
	} state_t;

	state_t state_q;
	res_t res_q;
	res_t res_in;
	logic [7:0] rem_q;
	logic [7:0] dvd_q;
	logic [CHR_CNT_W-1:0] dvs_q;
	logic [1:0] step_q;
	logic [CHR_CNT_W-1:0] dvs;
	logic [7:0] rem_a;
	logic [7:0] rem_b;
	logic out_free;

	function automatic logic [7:0] rstep(input logic [7:0] r, input logic b,
			input logic [CHR_CNT_W-1:0] d);
		logic [CHR_CNT_W-1:0] t;
		logic [CHR_CNT_W-1:0] s;
		t = CHR_CNT_W'({r, b});
		s = t - d;
		rstep = (t >= d) ? s[7:0] : t[7:0];
	endfunction

	assign pop = state_q == S_IDLE && !q_empty;
	assign out_free = !out_valid || out_ready;
	assign dvs = (q_req.effect == EFF_PRG) ? CHR_CNT_W'(prg_count) : chr_count;
	assign rem_a = rstep(rem_q, dvd_q[7], dvs_q);
	assign rem_b = rstep(rem_a, dvd_q[6], dvs_q);

	always_comb begin
		res_in = '0;
		res_in.effect = q_req.effect;
		res_in.slot = q_req.slot;
		res_in.mirror_mode = q_req.mirror;
		res_in.irq_request = q_req.effect == EFF_IRQ;
		if ((q_req.effect == EFF_PRG || q_req.effect == EFF_CHR) && dvs == '0) begin
			res_in.effect = EFF_NONE;
			res_in.slot = 3'd0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				res_q <= res_in;
				rem_q <= 8'd0;
				dvd_q <= q_req.value;
				dvs_q <= dvs;
			end
			S_DIV: begin
				rem_q <= rem_b;
				dvd_q <= {dvd_q[5:0], 2'b00};
				res_q.bank <= rem_b;
			end
			default: rem_q <= rem_q;
		endcase
		if (state_q == S_DONE && out_free)
			out_res <= res_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q <= 2'd0;
			out_valid <= 1'b0;
		end else begin
			if (state_q == S_DONE && out_free)
				out_valid <= 1'b1;
			else if (out_valid && out_ready)
				out_valid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					step_q <= 2'd0;
					if (pop) begin
						if ((q_req.effect == EFF_PRG || q_req.effect == EFF_CHR) && dvs != '0)
							state_q <= S_DIV;
						else
							state_q <= S_DONE;
					end
				end
				S_DIV: begin
					step_q <= step_q + 2'd1;
					if (step_q == 2'd3)
						state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### hdl/bank_switch_mapper_scanline_irq_top.sv
// Top level of the bank switch mapper with scanline interrupt counter.
// Each request (CPU bus write or scanline tick) gives exactly one result. The front end
// takes a request every cycle while its two-entry queue has room and updates mapper
// state at once; the back end retires one request at a time. A bank write with a nonzero
// page count passes the remainder unit, which reduces the bank number by the page count
// two bits per cycle; any other request skips the remainder unit. Page count writes take
// effect for requests popped from the queue afterwards.
module bank_switch_mapper_scanline_irq_top (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [bsmirq_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bsmirq_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [23:0] s_tdata,   // addr[15:0], data[23:16]
	input  logic s_tuser,          // kind
	output logic m_tvalid,
	input  logic m_tready,
	output logic [23:0] m_tdata    // effect[2:0], slot[5:3], bank[13:6], mirror_mode[15:14],
	                               // irq_request[16], zero[23:17]
);
	import bsmirq_pkg::*;

	logic [PRG_CNT_W-1:0] prg_count_q;
	logic [CHR_CNT_W-1:0] chr_count_q;
	logic push;
	logic pop;
	logic q_full;
	logic q_empty;
	req_t push_req;
	req_t pop_req;
	res_t out_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prg_count_q <= PRG_COUNT_RST;
			chr_count_q <= CHR_COUNT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PRG_COUNT: prg_count_q <= cfg_data[PRG_CNT_W-1:0];
				CFG_CHR_COUNT: chr_count_q <= cfg_data[CHR_CNT_W-1:0];
				default: prg_count_q <= prg_count_q;
			endcase
		end
	end

	bsmirq_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_tvalid),
		.kind(s_tuser),
		.addr(s_tdata[15:0]),
		.data(s_tdata[23:16]),
		.q_full(q_full),
		.in_ready(s_tready),
		.push(push),
		.push_req(push_req)
	);

	bsmirq_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_req(push_req),
		.pop(pop),
		.full(q_full),
		.empty(q_empty),
		.pop_req(pop_req)
	);

	bsmirq_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.prg_count(prg_count_q),
		.chr_count(chr_count_q),
		.q_empty(q_empty),
		.q_req(pop_req),
		.pop(pop),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_res(out_res)
	);

	assign m_tdata = {(24 - RES_W)'(0), out_res};

endmodule

### hdl/bsmirq_checker.sv
// Port-level checker for the mapper top level, bound to it.
module bsmirq_checker (
	input logic clk,
	input logic arst_n,
	input logic m_tvalid,
	input logic m_tready,
	input logic [23:0] m_tdata
);
	import bsmirq_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_reset_quiet: assert property (@(posedge clk)
		$rose(arst_n) |-> !m_tvalid)
		else $error("result valid out of reset");

	a_irq_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[16] == (m_tdata[2:0] == EFF_IRQ))
		else $error("interrupt flag does not match effect");

	a_none_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2:0] == EFF_NONE |-> m_tdata[23:3] == '0)
		else $error("no-effect result carries data");

	a_effect_legal: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2] |-> m_tdata[1:0] == 2'b00 && m_tdata[15:3] == '0)
		else $error("interrupt result malformed");

endmodule

bind bank_switch_mapper_scanline_irq_top bsmirq_checker u_bsmirq_checker (
	.clk(clk),
	.arst_n(arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata)
);

### verif/bank_switch_mapper_scanline_irq_top_test.sv
// Self-checking stream testbench for the bank switch mapper with scanline interrupt counter.
module bank_switch_mapper_scanline_irq_top_test;
	import bsmirq_pkg::*;

	typedef struct packed {
		logic kind;
		logic [15:0] addr;
		logic [7:0] data;
		logic typed;
		res_t want;
	} map_step_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic s_tvalid;
	logic s_tready;
	logic [23:0] s_tdata;
	logic s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [23:0] m_tdata;

	// mapper state as the checker sees it
	logic [PRG_CNT_W-1:0] prg_pages;
	logic [CHR_CNT_W-1:0] chr_pages;
	logic [7:0] chr_regs [8];
	logic swap_mode;
	logic [1:0] irq_en;
	logic [7:0] irq_cnt;
	logic [7:0] irq_latch;

	res_t mapper_results_due [$];
	int fault_count = 0;
	int feed_gap_pct = 38;
	int drain_gap_pct = 38;
	bit hold_off_req = 0;

	// directed requests right after reset: page counts 2 and 8
	map_step_t dir_steps [0:24] = '{
		'{1'b0, 16'h0000, 8'hFF, 1'b1, '{1'b0, 2'd0, 8'd0, 3'd0, EFF_NONE}},
		'{1'b0, 16'h7FFF, 8'hA5, 1'b1, '{1'b0, 2'd0, 8'd0, 3'd0, EFF_NONE}},
		'{1'b1, 16'hFFFF, 8'hFF, 1'b1, '{1'b0, 2'd0, 8'd0, 3'd0, EFF_NONE}},
		'{1'b0, 16'h8000, 8'hFF, 1'b1, '{1'b0, 2'd0, 8'd1, 3'd0, EFF_PRG}},
		'{1'b0, 16'hA00F, 8'h00, 1'b1, '{1'b0, 2'd0, 8'd0, 3'd1, EFF_PRG}},
		'{1'b0, 16'h9000, 8'h00, 1'b1, '{1'b0, 2'd1, 8'd0, 3'd0, EFF_MIRROR}},
		'{1'b0, 16'h9001, 8'h03, 1'b1, '{1'b0, 2'd2, 8'd0, 3'd0, EFF_MIRROR}},
		'{1'b0, 16'h9004, 8'hFE, 1'b1, '{1'b0, 2'd3, 8'd0, 3'd0, EFF_MIRROR}},
		'{1'b0, 16'h9002, 8'h02, 1'b1, '{1'b0, 2'd0, 8'd0, 3'd0, EFF_NONE}},
		'{1'b0, 16'h8003, 8'h05, 1'b1, '{1'b0, 2'd0, 8'd1, 3'd2, EFF_PRG}},
		'{1'b0, 16'h9008, 8'hFD, 1'b1, '{1'b0, 2'd0, 8'd0, 3'd0, EFF_NONE}},
		'{1'b0, 16'h8000, 8'h02, 1'b1, '{1'b0, 2'd0, 8'd0, 3'd0, EFF_PRG}},
		'{1'b0, 16'hB000, 8'h0F, 1'b1, '{1'b0, 2'd0, 8'd7, 3'd0, EFF_CHR}},
		'{1'b0, 16'hB001, 8'hFF, 1'b1, '{1'b0, 2'd0, 8'd7, 3'd0, EFF_CHR}},
		'{1'b0, 16'hE00C, 8'h0A, 1'b1, '{1'b0, 2'd0, 8'd7, 3'd7, EFF_CHR}},
		'{1'b0, 16'hC002, 8'hF3, 1'b1, '{1'b0, 2'd0, 8'd3, 3'd3, EFF_CHR}},
		'{1'b0, 16'hD00F, 8'hF0, 1'b1, '{1'b0, 2'd0, 8'd5, 3'd5, EFF_CHR}},
		'{1'b0, 16'hF000, 8'hFE, 1'b1, '{1'b0, 2'd0, 8'd0, 3'd0, EFF_NONE}},
		'{1'b0, 16'hF001, 8'h0F, 1'b1, '{1'b0, 2'd0, 8'd0, 3'd0, EFF_NONE}},
		'{1'b0, 16'hF002, 8'h02, 1'b1, '{1'b0, 2'd0, 8'd0, 3'd0, EFF_NONE}},
		'{1'b1, 16'h0000, 8'h00, 1'b0, '{1'b0, 2'd0, 8'd0, 3'd0, EFF_NONE}},
		'{1'b1, 16'h0000, 8'h00, 1'b0, '{1'b0, 2'd0, 8'd0, 3'd0, EFF_NONE}},
		'{1'b1, 16'h0000, 8'h00, 1'b0, '{1'b0, 2'd0, 8'd0, 3'd0, EFF_NONE}},
		'{1'b0, 16'hF00A, 8'h03, 1'b0, '{1'b0, 2'd0, 8'd0, 3'd0, EFF_NONE}},
		'{1'b0, 16'hFFFF, 8'h00, 1'b0, '{1'b0, 2'd0, 8'd0, 3'd0, EFF_NONE}}
	};

	bank_switch_mapper_scanline_irq_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// expected result of one request; advances the mapper state copy
	function automatic res_t mapper_predict(logic kind, logic [15:0] addr, logic [7:0] data);
		res_t r;
		logic [3:0] nib;
		logic [1:0] sub;
		logic [2:0] idx;
		logic [7:0] reg_v;
		r = '0;
		nib = addr[15:12];
		sub = addr[3:2] | addr[1:0];
		if (kind) begin
			if (irq_en[1]) begin
				if (irq_cnt == CNT_TOP) begin
					irq_cnt = irq_latch;
					irq_en[1] = irq_en[0];
					r.effect = EFF_IRQ;
					r.irq_request = 1'b1;
				end else begin
					irq_cnt = irq_cnt + 8'd1;
				end
			end
		end else if (nib == NIB_PRG_A || nib == NIB_PRG_B) begin
			if (prg_pages != 0) begin
				r.effect = EFF_PRG;
				r.slot = (nib == NIB_PRG_B) ? 3'd1 : (swap_mode ? 3'd2 : 3'd0);
				r.bank = 8'(data % prg_pages);
			end
		end else if (nib == NIB_MIRROR) begin
			if (!sub[1]) begin
				r.effect = EFF_MIRROR;
				r.mirror_mode = data[1:0] ^ 2'b01;
			end else begin
				swap_mode = data[1];
			end
		end else if (nib >= NIB_CHR_FIRST && nib <= NIB_CHR_LAST) begin
			idx = {2'(nib - NIB_CHR_FIRST), sub[1]};
			reg_v = chr_regs[idx];
			if (sub[0])
				reg_v[7:4] = data[3:0];
			else
				reg_v[3:0] = data[3:0];
			chr_regs[idx] = reg_v;
			if (chr_pages != 0) begin
				r.effect = EFF_CHR;
				r.slot = idx;
				r.bank = 8'(reg_v % chr_pages);
			end
		end else if (nib == NIB_IRQ) begin
			case (sub)
				IRQ_LATCH_LO: irq_latch[3:0] = data[3:0];
				IRQ_LATCH_HI: irq_latch[7:4] = data[3:0];
				IRQ_CONTROL: begin
					irq_en = data[1:0];
					if (irq_en[1])
						irq_cnt = irq_latch;
				end
				IRQ_ACK: irq_en[1] = irq_en[0];
				default: irq_en = irq_en;
			endcase
		end
		return r;
	endfunction

	task automatic note_fault(string what);
		fault_count++;
		if (fault_count <= 10)
			$display("%s", what);
	endtask

	task automatic send_request(logic kind, logic [15:0] addr, logic [7:0] data, logic typed,
			res_t want);
		res_t predicted;
		while ($urandom_range(99) < feed_gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {data, addr};
		do @(posedge clk); while (!s_tready);
		predicted = mapper_predict(kind, addr, data);
		mapper_results_due.push_back(typed ? want : predicted);
	endtask

	// interrupt group address; the code lands in A1:A0 or A3:A2
	function automatic logic [15:0] irq_addr(logic [1:0] code, logic [11:0] r);
		return {NIB_IRQ, r[11:4], r[0] ? {code, 2'b00} : {2'b00, code}};
	endfunction

	task automatic send_random_traffic(int count);
		int n;
		int pick;
		logic [15:0] a;
		logic [7:0] d;
		n = 0;
		while (n < count) begin
			pick = $urandom_range(99);
			a = 16'($urandom);
			d = 8'($urandom);
			if (pick < 8) begin
				send_request(1'($urandom), a, d, 1'b0, '0);
				n++;
			end else if (pick < 58) begin
				send_request(1'b1, a, d, 1'b0, '0);
				n++;
			end else if (pick < 63) begin
				// latch near the top, then arm with a counter load
				send_request(1'b0, irq_addr(IRQ_LATCH_LO, a[11:0]), {d[7:4], 1'b1, d[2:0]},
					1'b0, '0);
				send_request(1'b0, irq_addr(IRQ_LATCH_HI, a[11:0]), {d[7:4], 4'hF}, 1'b0, '0);
				send_request(1'b0, irq_addr(IRQ_CONTROL, a[11:0]), {d[7:2], 1'b1, d[0]},
					1'b0, '0);
				n += 3;
			end else if (pick < 68) begin
				send_request(1'b0, irq_addr(IRQ_ACK, a[11:0]), d, 1'b0, '0);
				n++;
			end else begin
				send_request(1'b0, {4'($urandom_range(NIB_PRG_A, NIB_CHR_LAST)), a[11:0]}, d,
					1'b0, '0);
				n++;
			end
		end
		s_tvalid <= 1'b0;
	endtask

	task automatic set_page_counts(logic [PRG_CNT_W-1:0] prg, logic [CHR_CNT_W-1:0] chr);
		cfg_we <= 1'b1;
		cfg_index <= CFG_PRG_COUNT;
		cfg_data <= CFG_DATA_W'(prg);
		@(posedge clk);
		cfg_index <= CFG_CHR_COUNT;
		cfg_data <= chr;
		@(posedge clk);
		cfg_we <= 1'b0;
		prg_pages = prg;
		chr_pages = chr;
	endtask

	task automatic drain_results();
		while (mapper_results_due.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	// stimulus
	initial begin
		logic [PRG_CNT_W-1:0] prg_set [6];
		logic [CHR_CNT_W-1:0] chr_set [6];
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tuser = 1'b0;
		s_tdata = '0;
		prg_pages = PRG_COUNT_RST;
		chr_pages = CHR_COUNT_RST;
		for (int i = 0; i < 8; i++)
			chr_regs[i] = 8'(i);
		swap_mode = 1'b0;
		irq_en = '0;
		irq_cnt = '0;
		irq_latch = '0;
		prg_set = '{9'd1, 9'd510, 9'd0, 9'd2, 9'd3, 9'($urandom_range(1, 510))};
		chr_set = '{11'd0, 11'd2040, 11'd1, 11'd8, 11'd1000, 11'($urandom_range(0, 2040))};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < 25; i++)
			send_request(dir_steps[i].kind, dir_steps[i].addr, dir_steps[i].data,
				dir_steps[i].typed, dir_steps[i].want);
		s_tvalid <= 1'b0;

		for (int p = 0; p < 6; p++) begin
			drain_results();
			set_page_counts(prg_set[p], chr_set[p]);
			if (p == 1)
				hold_off_req = 1;
			if (p == 3) begin
				feed_gap_pct = 0;
				drain_gap_pct = 0;
			end else begin
				feed_gap_pct = 38;
				drain_gap_pct = 38;
			end
			send_random_traffic(165);
		end

		drain_results();
		if (fault_count == 0)
			$display("bank_switch_mapper_scanline_irq_top_test: clean");
		else
			$display("bank_switch_mapper_scanline_irq_top_test: errors");
		$finish;
	end

	// result side ready, with one long hold-off
	initial begin
		int hold_left;
		bit hold_done;
		hold_left = 0;
		hold_done = 0;
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left != 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else if (hold_off_req && !hold_done) begin
				hold_done = 1;
				hold_left = 300;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= drain_gap_pct);
			end
		end
	end

	always @(posedge clk) begin
		res_t got;
		res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = res_t'(m_tdata[RES_W-1:0]);
			if (mapper_results_due.size() == 0) begin
				note_fault($sformatf("unexpected result %h", m_tdata));
			end else begin
				want = mapper_results_due.pop_front();
				if (got.effect != want.effect || got.slot != want.slot
						|| got.bank != want.bank || got.mirror_mode != want.mirror_mode
						|| got.irq_request != want.irq_request || m_tdata[23:RES_W] != '0)
					note_fault($sformatf({"mismatch: want eff %0d slot %0d bank %0d mir %0d ",
						"irq %0d, got eff %0d slot %0d bank %0d mir %0d irq %0d pad %h"},
						want.effect, want.slot, want.bank, want.mirror_mode, want.irq_request,
						got.effect, got.slot, got.bank, got.mirror_mode, got.irq_request,
						m_tdata[23:RES_W]));
			end
		end
	end

	initial begin
		#2000000;
		$display("bank_switch_mapper_scanline_irq_top_test: errors");
		$finish;
	end

endmodule

### files.f
hdl/bsmirq_pkg.sv
hdl/bsmirq_front.sv
hdl/bsmirq_fifo.sv
hdl/bsmirq_back.sv
hdl/bank_switch_mapper_scanline_irq_top.sv
hdl/bsmirq_checker.sv
verif/bank_switch_mapper_scanline_irq_top_test.sv
